// ===== hdl/kct_pkg.sv =====
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types and codes for the keyed counter table and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package kct_pkg;

    localparam int ENTRIES = 16;
    localparam int KEY_W   = 16;
    localparam int CNT_W   = 32;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_GET    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SHORT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_SAT   = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] count;
        logic             free_seen;
    } t_chain;

    typedef struct packed {
        logic             commit;
        logic             upd;
        logic             clr;
        logic             alloc;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== hdl/kct_cell.sv =====
// ----------------------------------------------------------------------------
// kct_cell
// One table entry. It compares its key, joins the lookup chain from its lower
// neighbor and applies the commit command when it was selected.
// ----------------------------------------------------------------------------
`default_nettype none

module kct_cell
    import kct_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_look,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire t_cell_cmd        i_cmd,
    input  wire t_chain           i_chain,
    output t_chain                o_chain,
    output logic                  o_match,
    output logic                  o_take
);

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic [CNT_W-1:0] r_count;
    logic             r_match;
    logic             r_take;
    logic             w_match;
    logic             w_take;

    assign w_match = r_valid && (r_key == i_key);
    assign w_take  = !r_valid && !i_chain.free_seen;

    always_comb begin
        o_chain.hit       = i_chain.hit | w_match;
        o_chain.count     = i_chain.count | (w_match ? r_count : '0);
        o_chain.free_seen = i_chain.free_seen | !r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
            r_take  <= 1'b0;
        end else begin
            if (i_look) begin
                r_match <= w_match;
                r_take  <= w_take;
            end
            if (i_cmd.commit) begin
                if (r_match && i_cmd.clr) begin
                    r_valid <= 1'b0;
                end
                if (r_take && i_cmd.alloc) begin
                    r_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_match && i_cmd.upd) begin
                r_count <= i_cmd.count;
            end
            if (r_take && i_cmd.alloc) begin
                r_key   <= i_cmd.key;
                r_count <= i_cmd.count;
            end
        end
    end

    assign o_match = r_match;
    assign o_take  = r_take;

endmodule

`default_nettype wire

// ===== hdl/keyed_counter_table.sv =====
// ----------------------------------------------------------------------------
// keyed_counter_table
// An associative table of key and count pairs built as a row of entry cells.
// Each beat carries an operation, a key and an amount: add accumulates with
// saturation or allocates the lowest free entry, get looks up the count, and
// remove subtracts and frees an entry whose count reaches exactly zero. Each
// input beat gives one result beat. An item passes through a lookup state,
// in which the key runs past every cell and the hit count and lowest free
// slot ripple down the cell chain, and a commit state that does the 32-bit
// add or subtract and writes the selected cell. The next beat is taken in the
// commit state, so the block takes no new item before the last one commits;
// a stalled result holds the commit state.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_counter_table
    import kct_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,  // op[1:0], key[17:2], amount[49:18], zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata   // count[31:0], status[33:32], zero pad
);

    t_state              r_state;
    t_state              n_state;
    logic [OP_W-1:0]     r_op;
    logic [KEY_W-1:0]    r_key;
    logic [CNT_W-1:0]    r_amt;
    logic                r_hit;
    logic [CNT_W-1:0]    r_hit_count;
    logic                r_full;
    logic                r_out_valid;
    logic [CNT_W-1:0]    r_out_count;
    logic [STAT_W-1:0]   r_out_status;
    logic [CNT_W-1:0]    n_out_count;
    logic [STAT_W-1:0]   n_out_status;

    logic                w_accept;
    logic                w_out_free;
    logic                w_look;
    logic                w_commit;
    t_cell_cmd           w_cmd;
    t_chain              w_chain [ENTRIES+1];
    logic [ENTRIES-1:0]  w_match;
    logic [ENTRIES-1:0]  w_take;
    logic [CNT_W:0]      w_sum;
    logic [CNT_W-1:0]    w_diff;

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_accept   = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (w_out_free) begin
                    n_state = s_axis_tvalid ? S_LOOK : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_look        = 1'b0;
        w_commit      = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_LOOK: begin
                w_look = 1'b1;
            end
            S_COMMIT: begin
                s_axis_tready = w_out_free;
                w_commit      = w_out_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= s_axis_tdata[1:0];
            r_key <= s_axis_tdata[17:2];
            r_amt <= s_axis_tdata[49:18];
        end
        if (w_look) begin
            r_hit       <= w_chain[ENTRIES].hit;
            r_hit_count <= w_chain[ENTRIES].count;
            r_full      <= !w_chain[ENTRIES].free_seen;
        end
    end

    assign w_chain[0] = '{hit: 1'b0, count: '0, free_seen: 1'b0};

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        kct_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_look  (w_look),
            .i_key   (r_key),
            .i_cmd   (w_cmd),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1]),
            .o_match (w_match[g]),
            .o_take  (w_take[g])
        );
    end

    assign w_sum  = {1'b0, r_hit_count} + {1'b0, r_amt};
    assign w_diff = r_hit_count - r_amt;

    always_comb begin
        w_cmd        = '0;
        w_cmd.commit = w_commit;
        w_cmd.key    = r_key;
        n_out_count  = '0;
        n_out_status = STAT_OK;
        case (r_op)
            OP_ADD: begin
                if (r_hit) begin
                    w_cmd.upd = 1'b1;
                    if (w_sum[CNT_W]) begin
                        w_cmd.count  = '1;
                        n_out_count  = '1;
                        n_out_status = STAT_SAT;
                    end else begin
                        w_cmd.count = w_sum[CNT_W-1:0];
                        n_out_count = w_sum[CNT_W-1:0];
                    end
                end else if (!r_full) begin
                    w_cmd.alloc = 1'b1;
                    w_cmd.count = r_amt;
                    n_out_count = r_amt;
                end else begin
                    n_out_status = STAT_FULL;
                end
            end
            OP_REMOVE: begin
                if (!r_hit) begin
                    n_out_status = STAT_SHORT;
                end else if (r_hit_count == r_amt) begin
                    w_cmd.clr = 1'b1;
                end else if (r_hit_count > r_amt) begin
                    w_cmd.upd   = 1'b1;
                    w_cmd.count = w_diff;
                    n_out_count = w_diff;
                end else begin
                    n_out_count  = r_hit_count;
                    n_out_status = STAT_SHORT;
                end
            end
            default: begin
                n_out_count = r_hit ? r_hit_count : '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_count  <= n_out_count;
            r_out_status <= n_out_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_status, r_out_count};

    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("more than one cell holds the same key");

    a_one_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_take))
        else $error("more than one cell picked as free slot");

    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> r_out_valid)
        else $error("commit did not load the result register");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == STAT_FULL)) |-> (r_out_count == '0))
        else $error("table full result carries a nonzero count");

endmodule

`default_nettype wire
